// ===== sv/sem_pkg.sv =====
`timescale 1ns / 1ps

package sem_pkg;

	localparam int MAX_WIDTH  = 2048;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CNT_W      = COL_W + 1;
	localparam int FW_W       = 12;
	localparam int ROW_W      = 16;
	localparam int CFG_W      = 16;
	localparam int PIX_W      = 24;
	localparam int ROOT_BITS  = 8;
	// gx/gy, squares, sum, then one stage per root bit
	localparam int LANE_DEPTH = 3 + ROOT_BITS;

	localparam logic [FW_W-1:0]  WIDTH_RESET  = 12'd640;
	localparam logic [ROW_W-1:0] HEIGHT_RESET = 16'd480;

	typedef enum logic [0:0] {
		REG_FRAME_WIDTH  = 1'b0,
		REG_FRAME_HEIGHT = 1'b1
	} reg_idx_t;

	typedef logic [PIX_W-1:0] rgb_t;
	// vertical column of the window: 0 top, 1 center row, 2 bottom
	typedef logic [2:0][PIX_W-1:0] col_t;

	typedef struct packed {
		logic valid;
		logic last;
		col_t left;
		col_t center;
		col_t right;
	} win_t;

	typedef struct packed {
		logic valid;
		logic last;
	} ctl_t;

endpackage

// ===== sv/sem_ram.sv =====
`timescale 1ns / 1ps

module sem_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 2048
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== sv/sem_front.sv =====
`timescale 1ns / 1ps

module sem_front (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       cfg_wen,
	input  logic [0:0]                 cfg_index,
	input  logic [sem_pkg::CFG_W-1:0]  cfg_data,
	input  logic                       adv,
	input  logic                       s_tvalid,
	input  logic [sem_pkg::PIX_W-1:0]  s_tdata,
	input  logic                       s_tuser,
	output sem_pkg::win_t              win
);

	logic [sem_pkg::FW_W-1:0]  width_q;
	logic [sem_pkg::ROW_W-1:0] height_q;
	logic [sem_pkg::CNT_W-1:0] col_q;
	logic [sem_pkg::ROW_W-1:0] row_q;

	logic [sem_pkg::CNT_W-1:0] eff_w;
	logic [sem_pkg::ROW_W-1:0] eff_h;
	logic [sem_pkg::CNT_W-1:0] col_inc;
	logic acc, flush, emit, wrap, last, ldup;
	logic [sem_pkg::PIX_W-1:0] pix;

	logic                      v_s1, wr_s1, top_s1, bot_s1, wrap_s1, ldup_s1, emit_s1, last_s1;
	logic [sem_pkg::COL_W-1:0] addr_s1;
	logic [sem_pkg::PIX_W-1:0] pix_s1;

	logic [sem_pkg::PIX_W-1:0] mid_rd, up_rd, mid_val, up_val;
	logic                      byp_q;
	logic [sem_pkg::PIX_W-1:0] byp_mid_q, byp_up_q;
	logic                      wen;
	sem_pkg::col_t             col_new, win1_q, win2_q;

	logic          vld_s2, last_s2;
	sem_pkg::col_t left_s2, center_s2, right_s2;

	always_comb begin
		if (width_q == '0) begin
			eff_w = sem_pkg::CNT_W'(1);
		end else if (width_q > sem_pkg::FW_W'(sem_pkg::MAX_WIDTH)) begin
			eff_w = sem_pkg::CNT_W'(sem_pkg::MAX_WIDTH);
		end else begin
			eff_w = sem_pkg::CNT_W'(width_q);
		end
		eff_h = (height_q == '0) ? sem_pkg::ROW_W'(1) : height_q;
	end

	assign acc     = s_tvalid && adv;
	assign col_inc = col_q + sem_pkg::CNT_W'(1);
	assign flush   = row_q >= eff_h;
	// no result until width+1 items of the frame are in
	assign emit    = (row_q > sem_pkg::ROW_W'(1)) || (row_q == sem_pkg::ROW_W'(1) && col_q != '0);
	// right neighbor is past the row end: replicate the last column
	assign wrap    = (col_q == '0) || (flush && col_q == eff_w);
	assign last    = flush && col_q == eff_w;
	assign ldup    = wrap ? (eff_w == sem_pkg::CNT_W'(1)) : (col_q == sem_pkg::CNT_W'(1));
	assign pix     = s_tuser ? '0 : s_tdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= sem_pkg::WIDTH_RESET;
			height_q <= sem_pkg::HEIGHT_RESET;
			col_q    <= '0;
			row_q    <= '0;
		end else if (cfg_wen) begin
			case (cfg_index)
				sem_pkg::REG_FRAME_WIDTH:  width_q  <= cfg_data[sem_pkg::FW_W-1:0];
				sem_pkg::REG_FRAME_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
			col_q <= '0;
			row_q <= '0;
		end else if (acc) begin
			if (!flush) begin
				if (col_inc >= eff_w) begin
					col_q <= '0;
					row_q <= row_q + sem_pkg::ROW_W'(1);
				end else begin
					col_q <= col_inc;
				end
			end else begin
				if (col_inc > eff_w) begin
					col_q <= '0;
					row_q <= '0;
				end else begin
					col_q <= col_inc;
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (adv) begin
			v_s1 <= acc;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			addr_s1 <= col_q[sem_pkg::COL_W-1:0];
			pix_s1  <= pix;
			wr_s1   <= !flush;
			top_s1  <= row_q == sem_pkg::ROW_W'(1);
			bot_s1  <= flush;
			wrap_s1 <= wrap;
			ldup_s1 <= ldup;
			emit_s1 <= emit;
			last_s1 <= last;
		end
	end

	assign wen = adv && v_s1 && wr_s1;

	sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_mid_ram (
		.clk   (clk),
		.we    (wen),
		.waddr (addr_s1),
		.wdata (pix_s1),
		.re    (acc),
		.raddr (col_q[sem_pkg::COL_W-1:0]),
		.rdata (mid_rd)
	);

	sem_ram #(.WIDTH(sem_pkg::PIX_W), .DEPTH(sem_pkg::MAX_WIDTH)) u_up_ram (
		.clk   (clk),
		.we    (wen),
		.waddr (addr_s1),
		.wdata (mid_val),
		.re    (acc),
		.raddr (col_q[sem_pkg::COL_W-1:0]),
		.rdata (up_rd)
	);

	// same-column write and read in one cycle (width of one): forward
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byp_q <= 1'b0;
		end else if (acc) begin
			byp_q <= wen && (col_q[sem_pkg::COL_W-1:0] == addr_s1);
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			byp_mid_q <= pix_s1;
			byp_up_q  <= mid_val;
		end
	end

	assign mid_val = byp_q ? byp_mid_q : mid_rd;
	assign up_val  = byp_q ? byp_up_q  : up_rd;

	always_comb begin
		col_new[0] = top_s1 ? mid_val : up_val;
		col_new[1] = mid_val;
		col_new[2] = bot_s1 ? mid_val : pix_s1;
	end

	always_ff @(posedge clk) begin
		if (adv && v_s1) begin
			win1_q    <= win2_q;
			win2_q    <= col_new;
			left_s2   <= ldup_s1 ? win2_q : win1_q;
			center_s2 <= win2_q;
			right_s2  <= wrap_s1 ? win2_q : col_new;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s2  <= 1'b0;
			last_s2 <= 1'b0;
		end else if (adv) begin
			vld_s2  <= v_s1 && emit_s1;
			last_s2 <= v_s1 && emit_s1 && last_s1;
		end
	end

	always_comb begin
		win.valid  = vld_s2;
		win.last   = last_s2;
		win.left   = left_s2;
		win.center = center_s2;
		win.right  = right_s2;
	end

`ifndef SYNTHESIS
	a_col_range: assert property (@(posedge clk) disable iff (!arst_n)
		col_q <= eff_w)
		else $error("column counter past row end");
	a_row_range: assert property (@(posedge clk) disable iff (!arst_n)
		row_q <= eff_h)
		else $error("row counter past frame end");
	a_last_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && last_s1 |-> emit_s1 && wrap_s1 && bot_s1)
		else $error("frame end not on the flush wrap");
`endif

endmodule

// ===== sv/sem_lane.sv =====
`timescale 1ns / 1ps

module sem_lane (
	input  logic            clk,
	input  logic            adv,
	input  logic [8:0][7:0] px,
	output logic [7:0]      mag
);

	localparam int RB = sem_pkg::ROOT_BITS;

	logic [9:0] pos_x, neg_x, pos_y, neg_y;
	logic signed [10:0] gx_s1, gy_s1;
	logic signed [21:0] gx2, gy2;
	logic [20:0] sqx_s2, sqy_s2;
	logic [21:0] sum;

	// index 0 is the sum stage, index k the stage deciding root bit RB-k
	logic [15:0]   val_s3 [RB+1];
	logic [15:0]   sq_s3  [RB+1];
	logic [RB-1:0] rt_s3  [RB+1];
	logic          sat_s3 [RB+1];

	assign pos_x = {2'b0, px[2]} + {1'b0, px[5], 1'b0} + {2'b0, px[8]};
	assign neg_x = {2'b0, px[0]} + {1'b0, px[3], 1'b0} + {2'b0, px[6]};
	assign pos_y = {2'b0, px[6]} + {1'b0, px[7], 1'b0} + {2'b0, px[8]};
	assign neg_y = {2'b0, px[0]} + {1'b0, px[1], 1'b0} + {2'b0, px[2]};

	always_ff @(posedge clk) begin
		if (adv) begin
			gx_s1 <= $signed({1'b0, pos_x}) - $signed({1'b0, neg_x});
			gy_s1 <= $signed({1'b0, pos_y}) - $signed({1'b0, neg_y});
		end
	end

	assign gx2 = gx_s1 * gx_s1;
	assign gy2 = gy_s1 * gy_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			sqx_s2 <= gx2[20:0];
			sqy_s2 <= gy2[20:0];
		end
	end

	assign sum = {1'b0, sqx_s2} + {1'b0, sqy_s2};

	always_ff @(posedge clk) begin
		if (adv) begin
			val_s3[0] <= sum[15:0];
			sat_s3[0] <= sum[21:16] != '0;
			sq_s3[0]  <= '0;
			rt_s3[0]  <= '0;
		end
	end

	for (genvar k = 1; k <= RB; k++) begin : g_root
		localparam int B = RB - k;
		logic [17:0] cand;
		// (r + 2^B)^2 = r^2 + r*2^(B+1) + 2^(2B)
		assign cand = {2'b0, sq_s3[k-1]} + ({10'b0, rt_s3[k-1]} << (B + 1))
			+ (18'd1 << (2 * B));
		always_ff @(posedge clk) begin
			if (adv) begin
				val_s3[k] <= val_s3[k-1];
				sat_s3[k] <= sat_s3[k-1];
				if (cand <= {2'b0, val_s3[k-1]}) begin
					rt_s3[k] <= rt_s3[k-1] | RB'(1 << B);
					sq_s3[k] <= cand[15:0];
				end else begin
					rt_s3[k] <= rt_s3[k-1];
					sq_s3[k] <= sq_s3[k-1];
				end
			end
		end
	end

	assign mag = sat_s3[RB] ? 8'hFF : rt_s3[RB];

endmodule

// ===== sv/sobel_edge_magnitude_3x3_top.sv =====
`timescale 1ns / 1ps
// Throughput: one request per cycle, output stalls aside; the result for a pixel leaves
// with the request width+1 positions later, so each frame ends with width+1 drain requests.
// Depth: line store read, window stage, lanes with an 8-stage square root, output register.
// Reset: counters cleared, frame 640x480, pipeline emptied; line stores keep contents.
module sobel_edge_magnitude_3x3_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      cfg_wen,
	input  logic [0:0]                cfg_index,
	input  logic [sem_pkg::CFG_W-1:0] cfg_data,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [23:0]               s_tdata,  // pixel_red, pixel_green, pixel_blue
	input  logic                      s_tuser,  // drain
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [23:0]               m_tdata,  // edge_red, edge_green, edge_blue
	output logic                      m_tlast   // frame_end
);

	localparam int LD = sem_pkg::LANE_DEPTH;

	logic                adv;
	sem_pkg::win_t       win;
	logic [2:0][8:0][7:0] lane_px;
	logic [2:0][7:0]     mag;
	sem_pkg::ctl_t       ctl_q [LD];
	logic                out_valid_q;
	logic [23:0]         out_data_q;
	logic                out_last_q;

	assign adv      = !out_valid_q || m_tready;
	assign s_tready = adv;

	sem_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_wen   (cfg_wen),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.adv       (adv),
		.s_tvalid  (s_tvalid),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.win       (win)
	);

	always_comb begin
		for (int ch = 0; ch < 3; ch++) begin
			for (int r = 0; r < 3; r++) begin
				lane_px[ch][r*3]   = win.left[r][8*ch +: 8];
				lane_px[ch][r*3+1] = win.center[r][8*ch +: 8];
				lane_px[ch][r*3+2] = win.right[r][8*ch +: 8];
			end
		end
	end

	for (genvar ch = 0; ch < 3; ch++) begin : g_lane
		sem_lane u_lane (
			.clk (clk),
			.adv (adv),
			.px  (lane_px[ch]),
			.mag (mag[ch])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < LD; i++) begin
				ctl_q[i] <= '0;
			end
		end else if (adv) begin
			ctl_q[0].valid <= win.valid;
			ctl_q[0].last  <= win.last;
			for (int i = 1; i < LD; i++) begin
				ctl_q[i] <= ctl_q[i-1];
			end
		end
	end

	// merge the three lanes into the output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			out_last_q  <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_q[LD-1].valid;
			out_last_q  <= ctl_q[LD-1].last;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {mag[2], mag[1], mag[0]};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign m_tlast  = out_last_q;

`ifndef SYNTHESIS
	a_stall_blocks_input: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |-> !s_tready)
		else $error("input taken while output stalled");
	a_last_valid: assert property (@(posedge clk) disable iff (!arst_n)
		ctl_q[LD-1].last |-> ctl_q[LD-1].valid)
		else $error("frame end flag on an empty slot");
`endif

endmodule
